>>> rtl/core/cgt_pkg.sv
// ----------------------------------------------------------------------------
// cgt_pkg: shared types and constants of the color gradient table generator
// Field widths, fixed-point layout, register indexes and the divider status.
// ----------------------------------------------------------------------------
`default_nettype none

package cgt_pkg;

  // item field widths
  localparam int IDX_W  = 10;  // entry index
  localparam int SLOT_W = 4;   // stop slot number
  localparam int POS_W  = 17;  // 1.16 stop position
  localparam int COL_W  = 8;   // one color channel
  localparam int CH_N   = 4;   // channels per color
  localparam int RGBA_W = COL_W * CH_N;
  localparam int STOP_W = POS_W + RGBA_W;  // one stored stop

  // configuration register widths
  localparam int TSZ_W  = 11;  // table_size
  localparam int SCNT_W = 5;   // stop_count
  localparam int CFG_W  = 11;  // widest register
  localparam int CIDX_W = 1;

  // fixed-point search target: index scaled by 1.0 of the position format
  localparam int FRAC_W = 16;
  localparam int TGT_W  = IDX_W + FRAC_W;

  // shared multiplier operands
  localparam int MUL_A_W = TGT_W;
  localparam int MUL_B_W = POS_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // serial divider: quotient never exceeds the channel difference
  localparam int QUO_W = COL_W;
  localparam int DVD_W = COL_W + TGT_W;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_STOP_COUNT = 1'b1;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/cgt_ram.sv
// ----------------------------------------------------------------------------
// cgt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/cgt_div.sv
// ----------------------------------------------------------------------------
// cgt_div: serial restoring divider
// Produces an unsigned quotient known to fit in QUO_W bits, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cgt_div #(
  parameter int DEN_W = 28
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [cgt_pkg::DVD_W-1:0]  dividend,
  input  wire logic [DEN_W-1:0]           divisor,
  output cgt_pkg::div_stat_t              stat,
  output logic      [cgt_pkg::QUO_W-1:0]  quotient
);

  import cgt_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);
  localparam int TRW   = DEN_W + QUO_W - 1;
  localparam int MW    = (TRW > DVD_W) ? TRW : DVD_W;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [TRW-1:0]   trial;
  logic             fits;

  // divisor aligned to the current quotient bit
  assign trial = TRW'(den_r) << cnt_r;
  assign fits  = MW'(rem_r) >= MW'(trial);

  // one compare-subtract step per cycle, msb first
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W - 1);
      rem_nxt  = dividend;
      den_nxt  = divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt        = DVD_W'(MW'(rem_r) - MW'(trial));
        quo_nxt[cnt_r] = 1'b1;
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

>>> rtl/core/color_gradient_table_generator.sv
// ----------------------------------------------------------------------------
// color_gradient_table_generator: gradient stop store and color map lookup
// Loads gradient stops and answers table entry queries with interpolated RGBA.
// ----------------------------------------------------------------------------
// Usage:
//   Input items are taken on start while busy is low. A load (in_action = 0)
//   writes one stop into the stop RAM in the accepting cycle and produces no
//   result; busy stays low, so loads can be issued every cycle. A query
//   (in_action = 1) raises busy until its result has been presented.
//   The result is shown for one cycle with out_valid; the receiver cannot
//   stall and must take it then. A new item may start in that same cycle.
//   Query steps: the stop search walks the stop RAM through the shared
//   multiplier, a read, multiply and compare per stop visited (k+1 stops
//   for a hit at stop k). An interpolated entry then runs each channel in
//   turn through one multiply, 8 serial divider steps and a handoff, for
//   all of RGBA. A finishing state follows, and out_valid is registered after it.
//   Configuration writes are always taken (cfg_ready high) and must only be
//   issued while busy is low. Reset sets table_size to 256, stop_count to 2
//   and idles the sequencer; stop contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module color_gradient_table_generator #(
  parameter int MAX_STOPS = 16,
  parameter int MAX_TABLE = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // command channel
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_action,
  input  wire logic [cgt_pkg::SLOT_W-1:0] in_stop_slot,
  input  wire logic [cgt_pkg::POS_W-1:0]  in_stop_position,
  input  wire logic [cgt_pkg::COL_W-1:0]  in_stop_red,
  input  wire logic [cgt_pkg::COL_W-1:0]  in_stop_green,
  input  wire logic [cgt_pkg::COL_W-1:0]  in_stop_blue,
  input  wire logic [cgt_pkg::COL_W-1:0]  in_stop_alpha,
  input  wire logic [cgt_pkg::IDX_W-1:0]  in_entry_index,
  // result channel
  output logic                            out_valid,
  output logic      [cgt_pkg::IDX_W-1:0]  out_entry_number,
  output logic      [cgt_pkg::COL_W-1:0]  out_red,
  output logic      [cgt_pkg::COL_W-1:0]  out_green,
  output logic      [cgt_pkg::COL_W-1:0]  out_blue,
  output logic      [cgt_pkg::COL_W-1:0]  out_alpha,
  // configuration channel
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [cgt_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [cgt_pkg::CFG_W-1:0]  cfg_data
);

  import cgt_pkg::*;

  localparam int AW = $clog2(MAX_STOPS);
  localparam int TW = $clog2(MAX_TABLE + 1);
  localparam int SW = $clog2(MAX_STOPS + 1);
  localparam int PW = POS_W + TW;              // scaled stop position
  localparam int CW = (PW > TGT_W) ? PW : TGT_W;
  localparam int CH_W = $clog2(CH_N);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RD     = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_CMP    = 8'b0000_1000,
    S_LMUL   = 8'b0001_0000,
    S_LSTART = 8'b0010_0000,
    S_LWAIT  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  // configuration registers
  logic [TSZ_W-1:0]  table_size_r;
  logic [SCNT_W-1:0] stop_count_r;

  // sequencer state
  state_t            state_r, state_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PW-1:0]     prev_prod_r, prev_prod_nxt;
  logic [RGBA_W-1:0] prev_col_r, prev_col_nxt;
  logic [TGT_W-1:0]  num_r, num_nxt;
  logic [PW-1:0]     den_r, den_nxt;
  logic [RGBA_W-1:0] c0_r, c0_nxt;
  logic [RGBA_W-1:0] c1_r, c1_nxt;
  logic [RGBA_W-1:0] res_r, res_nxt;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p_r;

  // stop RAM and divider
  logic              ram_we;
  logic [STOP_W-1:0] ram_wdata;
  logic [STOP_W-1:0] ram_rdata;
  logic [POS_W-1:0]  cur_pos;
  logic [RGBA_W-1:0] cur_col;
  logic              div_start;
  div_stat_t         div_stat;
  logic [QUO_W-1:0]  div_quo;

  // working values
  logic [TW-1:0]     t_eff;
  logic [SW-1:0]     n_eff;
  logic [AW-1:0]     last_k;
  logic [TGT_W-1:0]  target;
  logic [PW-1:0]     prod_pos;
  logic              hit;
  logic [COL_W-1:0]  lo, hi, diff, chan;
  logic              rising;

  // configuration writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TSZ_W'(256);
      stop_count_r <= SCNT_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TABLE_SIZE: table_size_r <= cfg_data[TSZ_W-1:0];
        CFG_STOP_COUNT: stop_count_r <= cfg_data[SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate table size and stop count to the supported range
  always_comb begin
    if (table_size_r < TSZ_W'(2)) begin
      t_eff = TW'(2);
    end else if (32'(table_size_r) > MAX_TABLE) begin
      t_eff = TW'(MAX_TABLE);
    end else begin
      t_eff = TW'(table_size_r);
    end
    if (stop_count_r < SCNT_W'(2)) begin
      n_eff = SW'(2);
    end else if (32'(stop_count_r) > MAX_STOPS) begin
      n_eff = SW'(MAX_STOPS);
    end else begin
      n_eff = SW'(stop_count_r);
    end
  end

  assign last_k = AW'(n_eff - 1'b1);

  // stop load goes straight into the RAM in the accepting cycle
  assign ram_we    = start && !busy && (in_action == ACT_LOAD)
                     && (32'(in_stop_slot) < MAX_STOPS);
  assign ram_wdata = {in_stop_position, in_stop_alpha, in_stop_blue,
                      in_stop_green, in_stop_red};

  cgt_ram #(
    .WIDTH (STOP_W),
    .DEPTH (MAX_STOPS)
  ) u_stop_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_stop_slot)),
    .wdata (ram_wdata),
    .raddr (k_r),
    .rdata (ram_rdata)
  );

  assign cur_pos = ram_rdata[STOP_W-1 -: POS_W];
  assign cur_col = ram_rdata[RGBA_W-1:0];

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    mul_p_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  assign prod_pos = mul_p_r[PW-1:0];
  assign target   = {idx_r, FRAC_W'(0)};
  assign hit      = (idx_r == '0) || (CW'(prod_pos) >= CW'(target));

  // current channel of the two bracketing stops
  assign lo     = c0_r[ch_r*COL_W +: COL_W];
  assign hi     = c1_r[ch_r*COL_W +: COL_W];
  assign rising = hi >= lo;
  assign diff   = rising ? (hi - lo) : (lo - hi);
  assign chan   = rising ? (lo + div_quo) : (lo - div_quo);

  cgt_div #(
    .DEN_W (PW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_p_r[DVD_W-1:0]),
    .divisor  (den_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // query sequencer
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    ch_nxt        = ch_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    prev_prod_nxt = prev_prod_r;
    prev_col_nxt  = prev_col_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    res_nxt       = res_r;
    mul_a         = MUL_A_W'(t_eff);
    mul_b         = cur_pos;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start && (in_action == ACT_QUERY)) begin
          idx_nxt   = in_entry_index;
          k_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          if ((k_r == '0) || (prod_pos <= prev_prod_r)
              || (CW'(target) < CW'(prev_prod_r))) begin
            res_nxt   = cur_col;
            state_nxt = S_DONE;
          end else begin
            den_nxt   = prod_pos - prev_prod_r;
            num_nxt   = TGT_W'(CW'(target) - CW'(prev_prod_r));
            c0_nxt    = prev_col_r;
            c1_nxt    = cur_col;
            ch_nxt    = '0;
            state_nxt = S_LMUL;
          end
        end else begin
          prev_prod_nxt = prod_pos;
          prev_col_nxt  = cur_col;
          if (k_r == last_k) begin
            res_nxt   = cur_col;
            state_nxt = S_DONE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_LMUL: begin
        mul_a     = num_r;
        mul_b     = MUL_B_W'(diff);
        state_nxt = S_LSTART;
      end
      S_LSTART: begin
        div_start = 1'b1;
        state_nxt = S_LWAIT;
      end
      S_LWAIT: begin
        if (div_stat.done) begin
          res_nxt[ch_r*COL_W +: COL_W] = chan;
          if (ch_r == CH_W'(CH_N - 1)) begin
            state_nxt = S_DONE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_LMUL;
          end
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    prev_prod_r <= prev_prod_nxt;
    prev_col_r  <= prev_col_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    c0_r        <= c0_nxt;
    c1_r        <= c1_nxt;
    res_r       <= res_nxt;
  end

  // outputs
  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_entry_number = idx_r;
  assign out_red          = res_r[0*COL_W +: COL_W];
  assign out_green        = res_r[1*COL_W +: COL_W];
  assign out_blue         = res_r[2*COL_W +: COL_W];
  assign out_alpha        = res_r[3*COL_W +: COL_W];

  // a result only follows a query in progress
  a_result_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE))
    else $error("result transfer without a finished query");

  // divider is never restarted while it works
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // the stop search never walks past the last stop in use
  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (k_r <= last_k))
    else $error("stop search index beyond stop count");

  // divider result arrives only while the sequencer waits for it
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_LWAIT))
    else $error("divider result with no waiting channel");

endmodule

`default_nettype wire

>>> tb/tb_color_gradient_table_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_color_gradient_table_generator: self-checking bench for the gradient table
// Loads gradient stops, queries table entries under several table sizes and
// stop counts, and checks every returned color against an in-bench predictor.
// ----------------------------------------------------------------------------

module tb_color_gradient_table_generator;

  import cgt_pkg::*;

  localparam int SETTLE_CYCLES  = 8;     // quiet time before a register write
  localparam int TAIL_CYCLES    = 120;   // longest query plus margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
  localparam int CALM_TAIL      = 60;    // last ops are sent without idling
  localparam int MAX_REPORTS    = 20;
  localparam int PHASE_ITEMS    = 73;

  typedef logic [CH_N-1:0][COL_W-1:0] rgba_t;  // [0] red .. [3] alpha

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic                action;
    logic [SLOT_W-1:0]   slot;
    logic [POS_W-1:0]    pos;
    rgba_t               rgba;
    logic [IDX_W-1:0]    idx;
    logic [CIDX_W-1:0]   reg_idx;
    logic [CFG_W-1:0]    reg_data;
  } stim_op_t;

  typedef struct packed {
    logic [IDX_W-1:0] entry;
    rgba_t            rgba;
  } entry_color_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // dut ports
  logic               start = 1'b0;
  logic               busy;
  logic               in_action = ACT_LOAD;
  logic [SLOT_W-1:0]  in_stop_slot = '0;
  logic [POS_W-1:0]   in_stop_position = '0;
  logic [COL_W-1:0]   in_stop_red = '0;
  logic [COL_W-1:0]   in_stop_green = '0;
  logic [COL_W-1:0]   in_stop_blue = '0;
  logic [COL_W-1:0]   in_stop_alpha = '0;
  logic [IDX_W-1:0]   in_entry_index = '0;
  logic               out_valid;
  logic [IDX_W-1:0]   out_entry_number;
  logic [COL_W-1:0]   out_red;
  logic [COL_W-1:0]   out_green;
  logic [COL_W-1:0]   out_blue;
  logic [COL_W-1:0]   out_alpha;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  color_gradient_table_generator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_stop_slot     (in_stop_slot),
    .in_stop_position (in_stop_position),
    .in_stop_red      (in_stop_red),
    .in_stop_green    (in_stop_green),
    .in_stop_blue     (in_stop_blue),
    .in_stop_alpha    (in_stop_alpha),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_entry_number (out_entry_number),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // shadow copy of the stop store and registers
  logic [POS_W-1:0]  shadow_pos [16];
  rgba_t             shadow_rgba [16];
  logic [TSZ_W-1:0]  shadow_tsize = 11'd256;
  logic [SCNT_W-1:0] shadow_scount = 5'd2;

  stim_op_t     stim_ops[$];
  entry_color_t awaited_colors[$];

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  logic        in_fire = 1'b0;
  logic        cfg_fire = 1'b0;

  // driver state
  stim_op_t    cur_op;
  logic        have_cur = 1'b0;
  logic        quiet = 1'b0;
  int unsigned gap_left = 0;
  int unsigned settle_left = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // color of one table entry from the shadow stops
  function automatic rgba_t interp_entry_color(input logic [IDX_W-1:0] idx);
    longint unsigned t, n, k, target, p0, p1, diff, q;
    rgba_t lo_c, hi_c, res;
    t = 64'(shadow_tsize);
    n = 64'(shadow_scount);
    if (t < 2) t = 2;
    if (t > 1024) t = 1024;
    if (n < 2) n = 2;
    if (n > 16) n = 16;
    if (idx == 0) return shadow_rgba[0];
    target = longint'(idx) << FRAC_W;
    // first stop whose scaled position reaches the target
    k = 0;
    while (k < n && longint'(shadow_pos[k]) * t < target) k++;
    if (k == n) return shadow_rgba[n-1];
    if (k == 0) return shadow_rgba[0];
    p0 = longint'(shadow_pos[k-1]) * t;
    p1 = longint'(shadow_pos[k]) * t;
    lo_c = shadow_rgba[k-1];
    hi_c = shadow_rgba[k];
    if (p1 <= p0 || target < p0) return hi_c;
    // per channel linear blend, quotient truncated toward zero
    for (int ch = 0; ch < CH_N; ch++) begin
      diff = (hi_c[ch] >= lo_c[ch]) ? 64'(hi_c[ch] - lo_c[ch]) : 64'(lo_c[ch] - hi_c[ch]);
      q = diff * (target - p0) / (p1 - p0);
      res[ch] = (hi_c[ch] >= lo_c[ch]) ? COL_W'(lo_c[ch] + q) : COL_W'(lo_c[ch] - q);
    end
    return res;
  endfunction

  // stimulus builders
  task automatic push_load(input logic [SLOT_W-1:0] slot, input logic [POS_W-1:0] pos,
                           input rgba_t rgba);
    stim_op_t op;
    op = '0;
    op.kind = OP_ITEM;
    op.action = ACT_LOAD;
    op.slot = slot;
    op.pos = pos;
    op.rgba = rgba;
    op.idx = IDX_W'($urandom_range(0, 1023));
    stim_ops = {stim_ops, op};
  endtask

  task automatic push_query(input logic [IDX_W-1:0] idx);
    stim_op_t op;
    op.kind = OP_ITEM;
    op.action = ACT_QUERY;
    op.slot = SLOT_W'($urandom);
    op.pos = POS_W'($urandom);
    op.rgba = $urandom;
    op.idx = idx;
    op.reg_idx = '0;
    op.reg_data = '0;
    stim_ops = {stim_ops, op};
  endtask

  task automatic push_cfg(input logic [CIDX_W-1:0] reg_idx, input logic [CFG_W-1:0] data);
    stim_op_t op;
    op = '0;
    op.kind = OP_CFG;
    op.reg_idx = reg_idx;
    op.reg_data = data;
    stim_ops = {stim_ops, op};
  endtask

  task automatic push_drain();
    stim_op_t op;
    op = '0;
    op.kind = OP_DRAIN;
    stim_ops = {stim_ops, op};
  endtask

  // driver: presents one op at a time, changes inputs on the falling edge
  always @(negedge clk) begin
    logic drive_start;
    logic drive_cfg;
    drive_start = 1'b0;
    drive_cfg = 1'b0;
    if (in_fire || cfg_fire) have_cur = 1'b0;
    if (rst_n && !have_cur) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (stim_ops.size() != 0) begin
        cur_op = stim_ops.pop_front();
        have_cur = 1'b1;
        settle_left = SETTLE_CYCLES;
        if (!quiet && stim_ops.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 16);
        if ($urandom_range(0, 40) == 0) quiet = !quiet;
      end
    end
    if (have_cur) begin
      case (cur_op.kind)
        OP_ITEM: drive_start = 1'b1;
        default: begin
          // registers change only with nothing in flight
          if (awaited_colors.size() == 0 && !busy) begin
            if (settle_left != 0) settle_left--;
            else if (cur_op.kind == OP_CFG) drive_cfg = 1'b1;
            else have_cur = 1'b0;
          end
        end
      endcase
    end
    start <= drive_start;
    cfg_valid <= drive_cfg;
    if (drive_start) begin
      in_action <= cur_op.action;
      in_stop_slot <= cur_op.slot;
      in_stop_position <= cur_op.pos;
      in_stop_red <= cur_op.rgba[0];
      in_stop_green <= cur_op.rgba[1];
      in_stop_blue <= cur_op.rgba[2];
      in_stop_alpha <= cur_op.rgba[3];
      in_entry_index <= cur_op.idx;
    end
    if (drive_cfg) begin
      cfg_index <= cur_op.reg_idx;
      cfg_data <= cur_op.reg_data;
    end
  end

  // monitor: samples transfers on the rising edge, predicts and checks
  always @(posedge clk) begin
    entry_color_t want;
    logic         took;
    took = 1'b0;
    in_fire <= rst_n && start && !busy;
    cfg_fire <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      // result transfer
      if (out_valid === 1'b1) begin
        took = 1'b1;
        if (awaited_colors.size() == 0) begin
          report_mismatch($sformatf("unexpected result for entry %0d", out_entry_number));
        end else begin
          want = awaited_colors.pop_front();
          if (out_entry_number !== want.entry)
            report_mismatch($sformatf("entry number %0d, expected %0d",
                                      out_entry_number, want.entry));
          if (out_red !== want.rgba[0])
            report_mismatch($sformatf("entry %0d red %0d, expected %0d",
                                      want.entry, out_red, want.rgba[0]));
          if (out_green !== want.rgba[1])
            report_mismatch($sformatf("entry %0d green %0d, expected %0d",
                                      want.entry, out_green, want.rgba[1]));
          if (out_blue !== want.rgba[2])
            report_mismatch($sformatf("entry %0d blue %0d, expected %0d",
                                      want.entry, out_blue, want.rgba[2]));
          if (out_alpha !== want.rgba[3])
            report_mismatch($sformatf("entry %0d alpha %0d, expected %0d",
                                      want.entry, out_alpha, want.rgba[3]));
        end
      end
      // register write transfer
      if (cfg_valid && cfg_ready) begin
        took = 1'b1;
        case (cfg_index)
          CFG_TABLE_SIZE: shadow_tsize = cfg_data[TSZ_W-1:0];
          CFG_STOP_COUNT: shadow_scount = cfg_data[SCNT_W-1:0];
          default: ;
        endcase
      end
      // command transfer
      if (start && !busy) begin
        took = 1'b1;
        if (in_action == ACT_LOAD) begin
          shadow_pos[in_stop_slot] = in_stop_position;
          shadow_rgba[in_stop_slot] = {in_stop_alpha, in_stop_blue, in_stop_green, in_stop_red};
        end else begin
          want.entry = in_entry_index;
          want.rgba = interp_entry_color(in_entry_index);
          awaited_colors = {awaited_colors, want};
        end
      end
      // watchdog
      if (took) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // stimulus plan and end of run
  initial begin
    logic [CFG_W-1:0] ts_list [10];
    logic [CFG_W-1:0] sc_list [10];
    int unsigned      gen_t, gen_n, count, pick, step;
    longint unsigned  pos;

    // every slot is written first, so no query ever reads an empty stop
    push_load(4'd0, 17'd8192, 32'hFF00FF00);
    push_load(4'd1, 17'd65536, 32'h00FF00FF);
    push_load(4'd2, 17'd65536, $urandom);
    push_load(4'd3, 17'h1FFFF, $urandom);
    for (int s = 4; s < 16; s++)
      push_load(SLOT_W'(s), POS_W'($urandom_range(0, 131071)), $urandom);
    // default registers: entry zero, before the first stop, blend, past the last stop
    push_query(10'd0);
    push_query(10'd1);
    push_query(10'd32);
    push_query(10'd33);
    push_query(10'd144);
    push_query(10'd256);
    push_query(10'd257);
    push_query(10'd1023);

    // register settings per phase, extremes and out-of-range values among them
    ts_list = '{11'd2, 11'd1024, 11'd0, 11'd2047, 11'd1, 11'd1025, 11'd300,
                11'($urandom), 11'd16, 11'($urandom_range(2, 1024))};
    sc_list = '{11'd2, 11'd16, 11'd0, 11'h7FF, 11'd1, 11'd17, 11'd5,
                11'($urandom), 11'h7F0, 11'($urandom_range(2, 16))};

    for (int ph = 0; ph < 10; ph++) begin
      push_cfg(CFG_TABLE_SIZE, ts_list[ph]);
      push_cfg(CFG_STOP_COUNT, sc_list[ph]);
      gen_t = 32'(ts_list[ph]);
      gen_n = 32'(sc_list[ph][SCNT_W-1:0]);
      if (gen_t < 2) gen_t = 2;
      if (gen_t > 1024) gen_t = 1024;
      if (gen_n < 2) gen_n = 2;
      if (gen_n > 16) gen_n = 16;
      count = 0;
      while (count < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          // rewrite the stops in use with rising positions, equal steps allowed
          step = 2 * 65536 / gen_n;
          pos = 64'($urandom_range(0, 8192));
          for (int s = 0; s < gen_n; s++) begin
            if (s == gen_n - 1 && $urandom_range(0, 2) == 0) pos = 65536;
            if (pos > 131071) pos = 131071;
            push_load(SLOT_W'(s), POS_W'(pos), $urandom);
            pos += 64'($urandom_range(0, step));
          end
          count += gen_n;
        end else if (pick < 20) begin
          // stray load anywhere, position above one allowed
          push_load(SLOT_W'($urandom), POS_W'($urandom_range(0, 131071)), $urandom);
          count++;
        end else if (pick < 22) begin
          push_drain();
        end else begin
          pick = $urandom_range(0, 19);
          if (pick == 0) push_query(10'd0);
          else if (pick < 3) push_query(IDX_W'($urandom_range(0, 1023)));
          else push_query(IDX_W'($urandom_range(1, gen_t - 1)));
          count++;
        end
      end
    end

    // release reset on a falling clock edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stim_ops.size() != 0 || have_cur || awaited_colors.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
